/* rtl/apc_pkg.sv */
// Package: shared types and constants for the pairwise combine block.
`timescale 1ns / 1ps
`default_nettype none
package apc_pkg;
   localparam int SUM_W  = 48;
   localparam int COEF_W = 32;
   localparam int FRAC_C = 24;
   localparam int FLOOR_W = 16;
   localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh0100_0000;

   typedef enum logic {
      REQ_STATS = 1'b0,
      REQ_APPLY = 1'b1
   } req_kind_type;

   typedef enum logic {
      KIND_REPORT  = 1'b0,
      KIND_ELEMENT = 1'b1
   } rsp_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_REPORT
   } back_state_type;
endpackage
`default_nettype wire

/* rtl/apc_stream_if.sv */
// Interface: valid/ready channel carrying one beat of a given payload type.
`timescale 1ns / 1ps
`default_nettype none
interface apc_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/apc_front.sv */
// Module: front stage, squares and products of each pair, into a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module apc_front #(
   parameter int ELEM_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire logic                        in_kind,
   input  wire logic signed [ELEM_BITS-1:0] in_a,
   input  wire logic signed [ELEM_BITS-1:0] in_b,
   input  wire logic                        in_last,
   output logic                             q_valid,
   input  wire logic                        q_ready,
   output logic                             q_kind,
   output logic signed [ELEM_BITS-1:0]      q_a,
   output logic signed [ELEM_BITS-1:0]      q_b,
   output logic                             q_last,
   output logic signed [2*ELEM_BITS-1:0]    q_ab,
   output logic signed [2*ELEM_BITS-1:0]    q_aa,
   output logic signed [2*ELEM_BITS-1:0]    q_bb
);
   localparam int PW = 2*ELEM_BITS;
   typedef struct packed {
      logic                 kind;
      logic signed [ELEM_BITS-1:0] a;
      logic signed [ELEM_BITS-1:0] b;
      logic                 last;
      logic signed [PW-1:0] ab;
      logic signed [PW-1:0] aa;
      logic signed [PW-1:0] bb;
   } entry_type;

   entry_type ent_ff [2];
   entry_type ent_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_ready;

   always_comb begin
      ent_in.kind = in_kind;
      ent_in.a    = in_a;
      ent_in.b    = in_b;
      ent_in.last = in_last;
      ent_in.ab   = in_a * in_b;
      ent_in.aa   = in_a * in_a;
      ent_in.bb   = in_b * in_b;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = pop  ? ~rd_ff : rd_ff;
      wr_in  = push ? ~wr_ff : wr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) ent_ff[wr_ff] <= ent_in;
   end

   assign q_kind = ent_ff[rd_ff].kind;
   assign q_a    = ent_ff[rd_ff].a;
   assign q_b    = ent_ff[rd_ff].b;
   assign q_last = ent_ff[rd_ff].last;
   assign q_ab   = ent_ff[rd_ff].ab;
   assign q_aa   = ent_ff[rd_ff].aa;
   assign q_bb   = ent_ff[rd_ff].bb;
endmodule
`default_nettype wire

/* rtl/apc_divider.sv */
// Module: restoring divider for one coefficient, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module apc_divider (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic signed [apc_pkg::SUM_W-1:0] dot,
   input  wire logic signed [apc_pkg::SUM_W-1:0] norm,
   input  wire logic [apc_pkg::FLOOR_W-1:0]      floor_val,
   output logic                                  done,
   output logic signed [apc_pkg::COEF_W-1:0]     coef
);
   // quotient = |dot|*2^23/norm; 34 quotient bits cover the saturating range
   localparam int SW = apc_pkg::SUM_W;
   localparam int QB = 34;
   localparam int NW = SW + 23;
   logic [NW-1:0]  num_ff, num_in;
   logic [SW:0]    rem_ff, rem_in;
   logic [SW-1:0]  den_ff, den_in;
   logic [QB-1:0]  q_ff, q_in;
   logic [6:0]     step_ff, step_in;
   logic           busy_ff, busy_in, neg_ff, neg_in, bypass_ff, bypass_in;
   logic           done_ff, done_in;
   logic [SW:0]    trial;
   logic [SW-1:0]  mag;
   logic signed [QB+1:0] wide;

   always_comb begin
      mag = dot[SW-1] ? SW'(-dot) : SW'(dot);
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff; q_in = q_ff;
      step_in = step_ff; busy_in = busy_ff; neg_in = neg_ff;
      bypass_in = bypass_ff; done_in = 1'b0;
      trial = {rem_ff[SW-1:0], num_ff[NW-1]} - {1'b0, den_ff};
      if (start) begin
         num_in = {mag, 23'd0};
         rem_in = '0;
         den_in = SW'(norm);
         q_in = '0;
         neg_in = dot[SW-1];
         bypass_in = (norm[SW-1] || norm == '0 || norm < SW'(floor_val));
         step_in = 7'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (bypass_ff || step_ff == 7'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            num_in = num_ff << 1;
            if (!trial[SW]) begin
               rem_in = trial;
               q_in   = {q_ff[QB-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[SW-1:0], num_ff[NW-1]};
               q_in   = {q_ff[QB-2:0], 1'b0};
            end
            // quotient beyond QB bits only saturates further; pin it
            if (q_ff[QB-1]) q_in = {1'b1, {(QB-1){1'b0}}};
            step_in = step_ff - 7'd1;
         end
      end
      wide = neg_ff ? (QB+2)'(apc_pkg::COEF_ONE) + $signed({2'b00, q_ff})
                    : (QB+2)'(apc_pkg::COEF_ONE) - $signed({2'b00, q_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in; q_ff <= q_in;
      step_ff <= step_in; neg_ff <= neg_in; bypass_ff <= bypass_in;
   end

   always_comb begin
      if (bypass_ff) coef = apc_pkg::COEF_ONE;
      else if (wide > (QB+2)'(64'sh7FFF_FFFF)) coef = 32'sh7FFF_FFFF;
      else if (wide < -(QB+2)'(64'sh8000_0000)) coef = -32'sh8000_0000;
      else coef = wide[apc_pkg::COEF_W-1:0];
   end
   assign done = done_ff;
endmodule
`default_nettype wire

/* rtl/apc_back.sv */
// Module: back stage, accumulates sums, runs dividers, forms combined elements.
`timescale 1ns / 1ps
`default_nettype none
module apc_back #(
   parameter int ELEM_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [apc_pkg::FLOOR_W-1:0]  norm_floor,
   input  wire logic                         q_valid,
   output logic                              q_ready,
   input  wire logic                         q_kind,
   input  wire logic signed [ELEM_BITS-1:0]  q_a,
   input  wire logic signed [ELEM_BITS-1:0]  q_b,
   input  wire logic                         q_last,
   input  wire logic signed [2*ELEM_BITS-1:0] q_ab,
   input  wire logic signed [2*ELEM_BITS-1:0] q_aa,
   input  wire logic signed [2*ELEM_BITS-1:0] q_bb,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic                              out_kind,
   output logic signed [ELEM_BITS-1:0]       out_value,
   output logic signed [apc_pkg::COEF_W-1:0] out_ca,
   output logic signed [apc_pkg::COEF_W-1:0] out_cb,
   output logic                              out_last
);
   localparam int SW = apc_pkg::SUM_W;
   localparam int CW = apc_pkg::COEF_W;
   localparam int PW = CW + ELEM_BITS;
   localparam logic signed [SW:0] SMAX = (SW+1)'({1'b0, {(SW-1){1'b1}}});
   localparam logic signed [SW:0] SMIN = -SMAX - (SW+1)'(1);
   localparam logic signed [PW+1:0] EMAX = (PW+2)'(2**(ELEM_BITS-1) - 1);

   apc_pkg::back_state_type st_ff, st_in;
   logic signed [SW-1:0] dot_ff, dot_in, aa_ff, aa_in, bb_ff, bb_in;
   logic signed [CW-1:0] ca_ff, ca_in, cb_ff, cb_in;
   logic signed [CW-1:0] mca_ff, mca_in, mcb_ff, mcb_in, oca_ff, oca_in, ocb_ff, ocb_in;
   logic signed [PW-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic                 mv_ff, mv_in, ml_ff, ml_in;
   logic                 ov_ff, ov_in, ok_ff, ok_in, ol_ff, ol_in;
   logic signed [ELEM_BITS-1:0] oval_ff, oval_in;
   logic                 div_start, da_done, db_done, dad_ff, dad_in, dbd_ff, dbd_in;
   logic signed [CW-1:0] div_ca, div_cb;
   logic                 take, stage_free, out_free;
   logic signed [PW+1:0] sum;
   logic signed [ELEM_BITS-1:0] sat;
   logic                 go_ff;

   function automatic logic signed [SW-1:0] sat_add(logic signed [SW-1:0] s,
                                                   logic signed [2*ELEM_BITS-1:0] p);
      logic signed [SW:0] t;
      t = (SW+1)'(s) + (SW+1)'(p);
      if (t > SMAX) return SMAX[SW-1:0];
      if (t < SMIN) return SMIN[SW-1:0];
      return t[SW-1:0];
   endfunction

   apc_divider u_div_a (.clock, .reset, .start(div_start), .dot(dot_ff), .norm(aa_ff),
      .floor_val(norm_floor), .done(da_done), .coef(div_ca));
   apc_divider u_div_b (.clock, .reset, .start(div_start), .dot(dot_ff), .norm(bb_ff),
      .floor_val(norm_floor), .done(db_done), .coef(div_cb));

   // product stage, then rounding into the output register at the end
   assign out_free   = !ov_ff || out_ready;
   assign stage_free = !mv_ff || out_free;

   always_comb begin
      sum = (PW+2)'(p1_ff) + (PW+2)'(p2_ff) + (PW+2)'(2**(apc_pkg::FRAC_C-1));
      sum = sum >>> apc_pkg::FRAC_C;
      if (sum > EMAX) sat = EMAX[ELEM_BITS-1:0];
      else if (sum < -EMAX - (PW+2)'(1)) sat = -EMAX[ELEM_BITS-1:0] - ELEM_BITS'(1);
      else sat = sum[ELEM_BITS-1:0];
   end

   always_comb begin
      st_in = st_ff; dot_in = dot_ff; aa_in = aa_ff; bb_in = bb_ff;
      ca_in = ca_ff; cb_in = cb_ff; dad_in = dad_ff; dbd_in = dbd_ff;
      p1_in = p1_ff; p2_in = p2_ff; mv_in = mv_ff; ml_in = ml_ff;
      ov_in = ov_ff; ok_in = ok_ff; ol_in = ol_ff; oval_in = oval_ff;
      mca_in = mca_ff; mcb_in = mcb_ff; oca_in = oca_ff; ocb_in = ocb_ff;
      take = 1'b0; q_ready = 1'b0;
      if (ov_ff && out_ready) ov_in = 1'b0;
      if (mv_ff && out_free) begin
         mv_in = 1'b0; ov_in = 1'b1; ok_in = apc_pkg::KIND_ELEMENT;
         oval_in = sat; ol_in = ml_ff;
         oca_in = mca_ff; ocb_in = mcb_ff;
      end
      case (st_ff)
         apc_pkg::BK_IDLE: begin
            q_ready = stage_free;
            take = q_valid && q_ready;
            if (take && q_kind == apc_pkg::REQ_APPLY) begin
               p1_in = ca_ff * q_a; p2_in = cb_ff * q_b;
               mca_in = ca_ff; mcb_in = cb_ff;
               mv_in = 1'b1; ml_in = q_last;
            end else if (take) begin
               dot_in = sat_add(dot_ff, q_ab);
               aa_in  = sat_add(aa_ff, q_aa);
               bb_in  = sat_add(bb_ff, q_bb);
               if (q_last) st_in = apc_pkg::BK_DIV;
            end
            if (take && q_kind == apc_pkg::REQ_STATS && q_last) begin
               dad_in = 1'b0; dbd_in = 1'b0;
            end
         end
         apc_pkg::BK_DIV: begin
            if (da_done) begin dad_in = 1'b1; ca_in = div_ca; end
            if (db_done) begin dbd_in = 1'b1; cb_in = div_cb; end
            if (dad_in && dbd_in) st_in = apc_pkg::BK_REPORT;
         end
         apc_pkg::BK_REPORT: begin
            if (!mv_ff && out_free && !(mv_ff)) begin
               ov_in = 1'b1; ok_in = apc_pkg::KIND_REPORT; oval_in = '0; ol_in = 1'b1;
               oca_in = ca_ff; ocb_in = cb_ff;
               dot_in = '0; aa_in = '0; bb_in = '0;
               st_in = apc_pkg::BK_IDLE;
            end
         end
         default: st_in = apc_pkg::BK_IDLE;
      endcase
   end

   // start dividers once the last statistics beat is taken, in the cycle the settled sums first appear
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= apc_pkg::BK_IDLE;
         dot_ff <= '0; aa_ff <= '0; bb_ff <= '0;
         ca_ff <= apc_pkg::COEF_ONE; cb_ff <= apc_pkg::COEF_ONE;
         mv_ff <= 1'b0; ov_ff <= 1'b0; go_ff <= 1'b0;
         dad_ff <= 1'b0; dbd_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         dot_ff <= dot_in; aa_ff <= aa_in; bb_ff <= bb_in;
         ca_ff <= ca_in; cb_ff <= cb_in;
         mv_ff <= mv_in; ov_ff <= ov_in;
         go_ff <= (st_ff == apc_pkg::BK_IDLE) && (st_in == apc_pkg::BK_DIV);
         dad_ff <= dad_in; dbd_ff <= dbd_in;
      end
      p1_ff <= p1_in; p2_ff <= p2_in; ml_ff <= ml_in;
      mca_ff <= mca_in; mcb_ff <= mcb_in; oca_ff <= oca_in; ocb_ff <= ocb_in;
      ok_ff <= ok_in; ol_ff <= ol_in; oval_ff <= oval_in;
   end
   assign div_start = go_ff;

   assign out_valid = ov_ff;
   assign out_kind  = ok_ff;
   assign out_value = oval_ff;
   assign out_ca    = oca_ff;
   assign out_cb    = ocb_ff;
   assign out_last  = ol_ff;
endmodule
`default_nettype wire

/* rtl/adasum_pair_combine.sv */
// Top level: pairwise adaptive-summation combine of two gradient vectors.
//
//  channel | dir | payload                                        | beat taken
//  req     | in  | req_type, a_value, b_value, last               | valid && ready
//  rsp     | out | result_kind, combined_value, coeff_a/b, is_last | valid && ready
//  csr     | in  | norm_floor (16 bits)                           | csr_wr_en
//
//  Statistics and apply beats move one per cycle, while rsp is not stalled,
//  through the front queue and the back accumulator or combine pipeline; an
//  apply result passes the product register, then the output register, to rsp.
//  A last statistics beat runs two 71-step restoring dividers in parallel
//  before the report beat; the back stage holds meanwhile.
//  Reset is synchronous, active high; coefficients return to 1.0, floor to 1.
//  A stall on rsp backs up through the output register into the queue.
`timescale 1ns / 1ps
`default_nettype none
module adasum_pair_combine #(
   parameter int ELEM_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   apc_stream_if.sink   req,
   apc_stream_if.source rsp,
   input  wire logic                         csr_wr_en,
   input  wire logic [apc_pkg::FLOOR_W-1:0]  csr_wr_data
);
   logic [apc_pkg::FLOOR_W-1:0] floor_ff;
   logic q_valid, q_ready, q_kind, q_last;
   logic signed [ELEM_BITS-1:0] q_a, q_b;
   logic signed [2*ELEM_BITS-1:0] q_ab, q_aa, q_bb;

   // hold the floor register; reset value is one LSB
   always_ff @(posedge clock) begin
      if (reset) floor_ff <= apc_pkg::FLOOR_W'(1);
      else if (csr_wr_en) floor_ff <= csr_wr_data;
   end

   apc_front #(.ELEM_BITS(ELEM_BITS)) u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .in_kind(req.payload.req_type), .in_a(req.payload.a_value),
      .in_b(req.payload.b_value), .in_last(req.payload.last),
      .q_valid, .q_ready, .q_kind, .q_a, .q_b, .q_last, .q_ab, .q_aa, .q_bb);

   apc_back #(.ELEM_BITS(ELEM_BITS)) u_back (
      .clock, .reset, .norm_floor(floor_ff),
      .q_valid, .q_ready, .q_kind, .q_a, .q_b, .q_last, .q_ab, .q_aa, .q_bb,
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_kind(rsp.payload.result_kind), .out_value(rsp.payload.combined_value),
      .out_ca(rsp.payload.coeff_a), .out_cb(rsp.payload.coeff_b),
      .out_last(rsp.payload.is_last));
endmodule
`default_nettype wire

/* rtl/apc_checker.sv */
// Checker: port-level properties of the pairwise combine block, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module apc_checker #(
   parameter int ELEM_BITS = 16
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic                 rsp_kind,
   input wire logic                 rsp_last,
   input wire logic [ELEM_BITS-1:0] rsp_value
);
   a_report_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == apc_pkg::KIND_REPORT |-> rsp_last) else $error("report not last");
   a_report_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == apc_pkg::KIND_REPORT |-> rsp_value == '0) else $error("report value");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)) else $error("rsp dropped");
   a_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid) else $error("valid after reset");
endmodule

bind adasum_pair_combine apc_checker #(.ELEM_BITS(ELEM_BITS)) u_apc_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_kind(rsp.payload.result_kind), .rsp_last(rsp.payload.is_last),
   .rsp_value(rsp.payload.combined_value));
`default_nettype wire
